// ===== design/atu_pkg.sv =====
// Package: shared types, constants and the arctangent table for the tilt angle unit.
package atu_pkg;

  // Number of micro-rotations; the table covers at most TABLE_LEN of them.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int IDX_W        = $clog2(TABLE_LEN);

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  // Vector magnitude stays below 2^33 after gain, so 36 bits leave margin.
  localparam int VEC_W    = 36;
  // Angle accumulator in 2^-16 centidegree, below 2^31 in magnitude.
  localparam int ANG_W    = 34;

  localparam int RES_W    = 20;
  localparam int OUT_LOW  = -9000;
  localparam int OUT_HIGH = 27000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [VEC_W-1:0]    vec_t;
  typedef logic signed [ANG_W-1:0]    ang_t;
  typedef logic signed [RES_W-1:0]    res_t;

  localparam ang_t DEG90_FX = ang_t'(64'sd589824000);

  // One beat's working set as it travels down the pipeline.
  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t acc;
    logic neg;   // accel_y was negative, so the angle is folded at the end
    logic zero;  // both samples zero, result forced to zero
  } cordic_t;

  // atan(2^-i) in degrees times 6553600, rounded.
  function automatic ang_t atan_lut(input logic [IDX_W-1:0] i);
    ang_t v;
    case (i)
      5'd0:    v = ang_t'(34'sd294912000);
      5'd1:    v = ang_t'(34'sd174096719);
      5'd2:    v = ang_t'(34'sd91987925);
      5'd3:    v = ang_t'(34'sd46694507);
      5'd4:    v = ang_t'(34'sd23437865);
      5'd5:    v = ang_t'(34'sd11730358);
      5'd6:    v = ang_t'(34'sd5866610);
      5'd7:    v = ang_t'(34'sd2933484);
      5'd8:    v = ang_t'(34'sd1466764);
      5'd9:    v = ang_t'(34'sd733385);
      5'd10:   v = ang_t'(34'sd366693);
      5'd11:   v = ang_t'(34'sd183346);
      5'd12:   v = ang_t'(34'sd91673);
      5'd13:   v = ang_t'(34'sd45837);
      5'd14:   v = ang_t'(34'sd22918);
      5'd15:   v = ang_t'(34'sd11459);
      5'd16:   v = ang_t'(34'sd5730);
      5'd17:   v = ang_t'(34'sd2865);
      5'd18:   v = ang_t'(34'sd1432);
      5'd19:   v = ang_t'(34'sd716);
      5'd20:   v = ang_t'(34'sd358);
      5'd21:   v = ang_t'(34'sd179);
      5'd22:   v = ang_t'(34'sd90);
      5'd23:   v = ang_t'(34'sd45);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/atu_if.sv =====
// Interfaces: the sample pair channel and the tilt result channel.
interface atu_in_if;
  import atu_pkg::*;
  logic    valid;
  logic    ready;
  sample_t accel_y;
  sample_t accel_z;

  modport source (output valid, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_y, input accel_z, output ready);
endinterface

interface atu_out_if;
  import atu_pkg::*;
  logic    valid;
  logic    ready;
  sample_t tilt_centideg;

  modport source (output valid, output tilt_centideg, input ready);
  modport sink   (input valid, input tilt_centideg, output ready);
endinterface

// ===== design/atu_cordic_stage.sv =====
// One registered vectoring micro-rotation with its own valid bit and ready.
module atu_cordic_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [atu_pkg::IDX_W-1:0] step_idx,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  atu_pkg::cordic_t        up_data,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output atu_pkg::cordic_t        dn_data
);
  import atu_pkg::*;

  logic    valid_r;
  cordic_t data_r;
  cordic_t data_nxt;
  vec_t    xs;
  vec_t    ys;
  ang_t    step_ang;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    xs       = $signed(up_data.x) >>> step_idx;
    ys       = $signed(up_data.y) >>> step_idx;
    step_ang = atan_lut(step_idx);
    data_nxt = up_data;
    // Turn toward the x axis; the sign of y picks the direction.
    if (!up_data.y[VEC_W-1]) begin
      data_nxt.x   = $signed(up_data.x) + ys;
      data_nxt.y   = $signed(up_data.y) - xs;
      data_nxt.acc = $signed(up_data.acc) + step_ang;
    end else begin
      data_nxt.x   = $signed(up_data.x) - ys;
      data_nxt.y   = $signed(up_data.y) + xs;
      data_nxt.acc = $signed(up_data.acc) - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/accel_tilt_angle_unit.sv =====
// Top level: pipelined CORDIC that turns a Y/Z accelerometer pair into a tilt angle.
//
//   Channel  Direction  Payload                         Beat accepted when
//   in_bus   sink       accel_y, accel_z (s16 each)     in_bus.valid && in_bus.ready
//   out_bus  source     tilt_centideg (s16, 0.01 deg)   out_bus.valid && out_bus.ready
//
// A beat enters every cycle while in_bus.ready is high; each beat passes through
// one entry stage, one stage per micro-rotation,
// one stage for the final fold, rounding and saturation.
// Reset (rst_n low at a clock edge) clears every valid bit; payload is not reset.
// Each stage has its own ready, so a stall at the output only stops the stages
// that hold a beat, and empty stages further up keep filling.
module accel_tilt_angle_unit (
  input logic     clk,
  input logic     rst_n,
  atu_in_if.sink   in_bus,
  atu_out_if.source out_bus
);
  import atu_pkg::*;

  // Stage k output lives at index k; index 0 is the entry register.
  cordic_t st_data  [0:NSTEPS];
  logic    st_valid [0:NSTEPS];
  logic    st_ready [0:NSTEPS];

  // ---------------------------------------------------------------------------
  // Entry stage: choose the argument order and pre-rotate into the right half plane.
  // ---------------------------------------------------------------------------
  logic    pre_valid_r;
  cordic_t pre_r;
  cordic_t pre_nxt;
  sample_t arg_a;
  sample_t arg_b;
  vec_t    a_fx;
  vec_t    b_fx;

  always_comb begin
    // For negative Y the angle is built from atan2(Z, Y) and folded at the end.
    if (!in_bus.accel_y[SAMPLE_W-1]) begin
      arg_a = in_bus.accel_y;
      arg_b = in_bus.accel_z;
    end else begin
      arg_a = in_bus.accel_z;
      arg_b = in_bus.accel_y;
    end
    a_fx = vec_t'({{(VEC_W-SAMPLE_W-FRAC_W){arg_a[SAMPLE_W-1]}}, arg_a, {FRAC_W{1'b0}}});
    b_fx = vec_t'({{(VEC_W-SAMPLE_W-FRAC_W){arg_b[SAMPLE_W-1]}}, arg_b, {FRAC_W{1'b0}}});

    pre_nxt.neg  = in_bus.accel_y[SAMPLE_W-1];
    pre_nxt.zero = (in_bus.accel_y == '0) && (in_bus.accel_z == '0);
    pre_nxt.x    = b_fx;
    pre_nxt.y    = a_fx;
    pre_nxt.acc  = '0;
    // A vector in the left half plane is turned a quarter turn toward +x first.
    if (arg_b[SAMPLE_W-1]) begin
      if (!arg_a[SAMPLE_W-1]) begin
        pre_nxt.x   = a_fx;
        pre_nxt.y   = -b_fx;
        pre_nxt.acc = DEG90_FX;
      end else begin
        pre_nxt.x   = -a_fx;
        pre_nxt.y   = b_fx;
        pre_nxt.acc = -DEG90_FX;
      end
    end
  end

  assign in_bus.ready = !pre_valid_r || st_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      pre_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      pre_r <= pre_nxt;
    end
  end

  assign st_data[0]  = pre_r;
  assign st_valid[0] = pre_valid_r;

  // ---------------------------------------------------------------------------
  // Micro-rotation stages, one register stage per step.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NSTEPS; k++) begin : g_step
    atu_cordic_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (IDX_W'(k)),
      .up_valid (st_valid[k]),
      .up_ready (st_ready[k]),
      .up_data  (st_data[k]),
      .dn_valid (st_valid[k+1]),
      .dn_ready (st_ready[k+1]),
      .dn_data  (st_data[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: fold negative-Y angles, round to centidegrees, saturate.
  // ---------------------------------------------------------------------------
  logic          out_valid_r;
  sample_t       out_tilt_r;
  sample_t       out_tilt_nxt;
  cordic_t       fin;
  logic signed [VEC_W-1:0] ang_full;
  logic signed [VEC_W-1:0] ang_rnd;
  res_t          res_cd;

  assign fin = st_data[NSTEPS];
  assign st_ready[NSTEPS] = !out_valid_r || out_bus.ready;

  always_comb begin
    if (fin.neg) begin
      ang_full = VEC_W'($signed(DEG90_FX)) - VEC_W'($signed(fin.acc));
    end else begin
      ang_full = VEC_W'($signed(fin.acc));
    end
    // Halfway values round toward plus infinity.
    ang_rnd = ang_full + VEC_W'(1 <<< (FRAC_W - 1));
    res_cd  = ang_rnd[FRAC_W +: RES_W];
    if (fin.zero) begin
      out_tilt_nxt = '0;
    end else if (res_cd < res_t'(OUT_LOW)) begin
      out_tilt_nxt = sample_t'(OUT_LOW);
    end else if (res_cd > res_t'(OUT_HIGH)) begin
      out_tilt_nxt = sample_t'(OUT_HIGH);
    end else begin
      out_tilt_nxt = res_cd[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_ready[NSTEPS]) begin
      out_valid_r <= st_valid[NSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[NSTEPS] && st_valid[NSTEPS]) begin
      out_tilt_r <= out_tilt_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.tilt_centideg = out_tilt_r;

endmodule
